// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; concurrent assertions are removed when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/tea_pkg.sv =====
// types, constants and round functions of the tea cipher
// used by tea_cell, tea_out_stage and tea_block_cipher
`default_nettype none

package tea_pkg;

   localparam int ROUNDS    = 32;
   localparam int NUM_CELLS = 2 * ROUNDS;
   localparam int WORD_W    = 32;
   localparam int NUM_KEYS  = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

   localparam logic [CSR_IDX_W-1:0] KEY0_IDX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] KEY1_IDX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] KEY2_IDX = 2'd2;
   localparam logic [CSR_IDX_W-1:0] KEY3_IDX = 2'd3;

   localparam logic FUNC_ENC = 1'b0;
   localparam logic FUNC_DEC = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [NUM_KEYS-1:0] key_type;

   typedef struct packed {
      logic     func;
      word_type word_first;
      word_type word_second;
   } req_type;

   typedef struct packed {
      word_type result_first;
      word_type result_second;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic func;
   } cell_ctrl_type;

   typedef struct packed {
      word_type y;
      word_type z;
   } cell_data_type;

   function automatic word_type mix(input word_type w, input word_type sum,
                                    input word_type ka, input word_type kb);
      word_type a;
      word_type b;
      word_type c;
      a = (w << 4) + ka;
      b = w + sum;
      c = (w >> 5) + kb;
      return a ^ b ^ c;
   endfunction

   // running sum of round r, evaluated on constants only
   function automatic word_type enc_sum(input int r);
      logic [WORD_W-1:0] k;
      k = WORD_W'(r + 1);
      return DELTA * k;
   endfunction

   function automatic word_type dec_sum(input int r);
      logic [WORD_W-1:0] k;
      k = WORD_W'(ROUNDS - r);
      return DELTA * k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tea_cell.sv =====
// one half round of tea: updates one word of the block from the other
// depends on tea_pkg; round sums and position are tied off by the top level
`default_nettype none

module tea_cell
   import tea_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          odd,
   input  wire word_type      sum_enc,
   input  wire word_type      sum_dec,
   input  wire key_type       keys,
   input  wire cell_ctrl_type ctrl_in,
   input  wire cell_data_type data_in,
   output cell_ctrl_type      ctrl_out,
   output cell_data_type      data_out
);

   cell_ctrl_type ctrl_ff;
   cell_data_type data_ff;
   cell_data_type data_in_nxt;

   logic     upd_y;
   word_type src;
   word_type tgt;
   word_type ka;
   word_type kb;
   word_type sum;
   word_type m;
   word_type res;

   // encrypt updates y in even cells, decrypt updates z first
   assign upd_y = ~(ctrl_in.func ^ odd);
   assign src   = upd_y ? data_in.z : data_in.y;
   assign tgt   = upd_y ? data_in.y : data_in.z;
   assign ka    = upd_y ? keys[0] : keys[2];
   assign kb    = upd_y ? keys[1] : keys[3];
   assign sum   = (ctrl_in.func == FUNC_DEC) ? sum_dec : sum_enc;
   assign m     = mix(src, sum, ka, kb);
   assign res   = (ctrl_in.func == FUNC_DEC) ? (tgt - m) : (tgt + m);

   always_comb begin
      data_in_nxt = data_in;
      if (upd_y) begin
         data_in_nxt.y = res;
      end else begin
         data_in_nxt.z = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      if (en) begin
         ctrl_ff.func <= ctrl_in.func;
         data_ff      <= data_in_nxt;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== rtl/tea_out_stage.sv =====
// output register behind the cell chain; holds a finished block while stalled
// depends on tea_pkg; produces the advance enable for the chain
`default_nettype none

module tea_out_stage
   import tea_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type last_ctrl,
   input  wire cell_data_type last_data,
   input  wire logic          rsp_stall,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   output logic               pipe_en
);

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   logic    load;

   assign load    = last_ctrl.valid && (!out_valid_ff || !rsp_stall);
   assign pipe_en = !(last_ctrl.valid && out_valid_ff && rsp_stall);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff.result_first  <= last_data.y;
         out_data_ff.result_second <= last_data.z;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tea_block_cipher.sv =====
// tea block cipher: takes one 64-bit block per cycle while req_stall is low and
// returns it encrypted or decrypted under the 128-bit key in registers 0 to 3.
// The work runs in a chain of 2*ROUNDS (64) half-round cells, one word update
// per cell, followed by an output register, and a new block can be taken every
// cycle while req_stall is low. A stalled result does not stop the input until
// the last cell also holds a block. Key writes apply to blocks in flight, so
// write keys only while the cipher is empty.
// depends on tea_pkg, tea_cell, tea_out_stage and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module tea_block_cipher
   import tea_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire word_type             csr_wdata
);

   key_type       key_ff;
   key_type       key_in;
   logic          pipe_en;
   cell_ctrl_type ctrl [NUM_CELLS+1];
   cell_data_type data [NUM_CELLS+1];

   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         unique case (csr_index)
            KEY0_IDX: key_in[0] = csr_wdata;
            KEY1_IDX: key_in[1] = csr_wdata;
            KEY2_IDX: key_in[2] = csr_wdata;
            KEY3_IDX: key_in[3] = csr_wdata;
            default:  key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign req_stall  = !pipe_en;
   assign ctrl[0].valid = req_valid;
   assign ctrl[0].func  = req_data.func;
   assign data[0].y     = req_data.word_first;
   assign data[0].z     = req_data.word_second;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      localparam word_type SUM_ENC = enc_sum(i / 2);
      localparam word_type SUM_DEC = dec_sum(i / 2);
      localparam logic     ODD     = 1'(i % 2);

      tea_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .odd      (ODD),
         .sum_enc  (SUM_ENC),
         .sum_dec  (SUM_DEC),
         .keys     (key_ff),
         .ctrl_in  (ctrl[i]),
         .data_in  (data[i]),
         .ctrl_out (ctrl[i+1]),
         .data_out (data[i+1])
      );
   end

   tea_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .last_ctrl (ctrl[NUM_CELLS]),
      .last_data (data[NUM_CELLS]),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .pipe_en   (pipe_en)
   );

   `ASSERT_PROP(a_accept_enters, clock, reset, req_valid && !req_stall |=> ctrl[1].valid, "lost")
   `ASSERT_PROP(a_rsp_kept, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped")
   `ASSERT_PROP(a_last_held, clock, reset, !pipe_en |=> $stable(data[NUM_CELLS]), "block moved")
   `ASSERT_PROP(a_last_valid, clock, reset, !pipe_en |=> ctrl[NUM_CELLS].valid, "block lost")
   `ASSERT_NEVER(a_stall_src, clock, reset, req_stall && !(rsp_valid && rsp_stall), "bad stall")

endmodule

`default_nettype wire
